@@ hdl/dfm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfm_pkg
// Shared types and constants of the drum membrane time-step engine.
// ----------------------------------------------------------------------------
package dfm_pkg;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_C,
        ST_RD_U,
        ST_RD_D,
        ST_RD_L,
        ST_RD_R,
        ST_NB_R,
        ST_M_CB,
        ST_M_P,
        ST_M_S,
        ST_M_R,
        ST_M_N,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_WB,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        REG_DAMPING_MU    = 3'd0,
        REG_COUPLING_RHO  = 3'd1,
        REG_BOUNDARY_GAIN = 3'd2,
        REG_LISTEN_COL    = 3'd3,
        REG_LISTEN_ROW    = 3'd4,
        REG_DOMAIN_COLS   = 3'd5,
        REG_DOMAIN_ROWS   = 3'd6
    } cfg_index_t;

    localparam logic KIND_CELL_WRITE = 1'b0;
    localparam logic KIND_AUDIO_STEP = 1'b1;

    localparam int CFG_BITS    = 18;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 16;
    localparam int DIV_BITS    = 17;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage
`default_nettype wire

@@ hdl/drumhead_fdtd_membrane_step.sv @@
`default_nettype none
// A cell write is taken in the idle state. An audio step covers every domain
// cell in use, and the sequencer visits one cell at a time: five reads at the
// shared read address of the two cell memories, three passes through the shared
// multiplier and a bit-serial divide.
// One audio step is handled at a time; the block is not ready while it works.
// Reset: a clearing pass over all GRID_ROWS*GRID_COLS cells zeroes the cell store.
// ----------------------------------------------------------------------------
// drumhead_fdtd_membrane_step
// Two-dimensional finite-difference drum membrane, one time step per sample.
// ----------------------------------------------------------------------------
module drumhead_fdtd_membrane_step #(
    parameter int GRID_COLS     = 64,
    parameter int GRID_ROWS     = 64,
    parameter int PRESSURE_BITS = 24
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [2:0]                      cfg_index,
    input  wire logic [dfm_pkg::CFG_BITS-1:0]    cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_kind,
    input  wire logic [5:0]                      s_cell_col,
    input  wire logic [5:0]                      s_cell_row,
    input  wire logic                            s_cell_is_wall,
    input  wire logic                            s_cell_excited,
    input  wire logic signed [dfm_pkg::SAMPLE_BITS-1:0] s_sample_in,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [dfm_pkg::SAMPLE_BITS-1:0] m_listener_pressure,
    output logic                                 m_clipped
);
    import dfm_pkg::*;

    localparam int W     = PRESSURE_BITS;
    localparam int DW    = W + 6;
    localparam int PW    = DW + 18;
    localparam int CBW   = W + 3;
    localparam int SW    = W + 2;
    localparam int NB    = W + 25;
    localparam int VW    = NB + 1;
    localparam int DEPTH = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(GRID_COLS);
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CCW   = $clog2(GRID_COLS + 1);
    localparam int RCW   = $clog2(GRID_ROWS + 1);
    localparam logic signed [VW-1:0] PMAX = VW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [VW-1:0] PMIN = -PMAX - VW'(1);

    state_t state_reg, state_next;

    logic [COEF_BITS-1:0]       mu_reg, rho_reg;
    logic signed [CFG_BITS-1:0] gain_reg;
    logic [6:0] lcol_reg, lrow_reg, dcols_reg, drows_reg;

    logic                  plane_reg;
    logic [CW-1:0]         c_reg;
    logic [RW-1:0]         r_reg;
    logic [CCW-1:0]        cols_reg;
    logic [RCW-1:0]        rows_reg;
    logic [AW-1:0]         clr_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [W-1:0]   cv_reg, pv_reg;
    logic                  exc_reg;
    logic signed [SW-1:0]  sa_reg;
    logic [2:0]            nw_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [CBW-1:0] cb_reg;
    logic signed [NB-1:0]  num_reg;
    logic signed [DW-1:0]  diff_reg;
    logic                  neg_reg;
    logic                  lis_ok_reg;
    logic signed [W-1:0]   lp_reg;
    logic                  clip_reg;
    logic                  m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_lp_reg;
    logic                  m_clip_reg;

    logic [AW-1:0]         addr_c, raddr, pr_waddr, fl_waddr;
    logic                  pr_we, fl_we;
    logic [2*W-1:0]        pr_wdata, pr_rdata;
    logic [1:0]            fl_wdata, fl_rdata;
    logic signed [W-1:0]   rd_cur, rd_oth;
    logic                  nb_bound, nb_wall;
    logic signed [DW-1:0]  mul_a;
    logic signed [CFG_BITS-1:0] mul_b;
    logic signed [PW-1:0]  prod_rnd;
    logic signed [CBW+2:0] nwcb;
    logic [DIV_BITS-1:0]   divisor;
    logic [NB-1:0]         mag, quotient;
    div_status_t           div_st;
    logic signed [VW-1:0]  v_raw, v_sum, v_sat;
    logic                  v_clip;
    logic                  in_grid, last_col, last_row, at_listener, out_free;
    logic signed [63:0]    lp_wide;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_reg    <= COEF_BITS'(66);
            rho_reg   <= COEF_BITS'(32768);
            gain_reg  <= '0;
            lcol_reg  <= 7'd1;
            lrow_reg  <= 7'd1;
            dcols_reg <= 7'd64;
            drows_reg <= 7'd64;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DAMPING_MU:    mu_reg    <= cfg_data[COEF_BITS-1:0];
                REG_COUPLING_RHO:  rho_reg   <= cfg_data[COEF_BITS-1:0];
                REG_BOUNDARY_GAIN: gain_reg  <= cfg_data;
                REG_LISTEN_COL:    lcol_reg  <= cfg_data[6:0];
                REG_LISTEN_ROW:    lrow_reg  <= cfg_data[6:0];
                REG_DOMAIN_COLS:   dcols_reg <= cfg_data[6:0];
                REG_DOMAIN_ROWS:   drows_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign addr_c   = AW'(int'(r_reg) * GRID_COLS + int'(c_reg));
    assign in_grid  = (int'(s_cell_col) < GRID_COLS) && (int'(s_cell_row) < GRID_ROWS);
    assign last_col = (int'(c_reg) + 1 == int'(cols_reg));
    assign last_row = (int'(r_reg) + 1 == int'(rows_reg));
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign at_listener = lis_ok_reg && (int'(c_reg) + 1 == int'(lcol_reg))
                         && (int'(r_reg) + 1 == int'(lrow_reg));

    // Read address of the cell store per sequencer step.
    always_comb begin
        case (state_reg)
            ST_RD_U: raddr = (r_reg == '0) ? addr_c : AW'(addr_c - AW'(GRID_COLS));
            ST_RD_D: raddr = last_row ? addr_c : AW'(addr_c + AW'(GRID_COLS));
            ST_RD_L: raddr = (c_reg == '0) ? addr_c : AW'(addr_c - AW'(1));
            ST_RD_R: raddr = last_col ? addr_c : AW'(addr_c + AW'(1));
            default: raddr = addr_c;
        endcase
    end

    assign rd_cur = plane_reg ? pr_rdata[2*W-1:W] : pr_rdata[W-1:0];
    assign rd_oth = plane_reg ? pr_rdata[W-1:0] : pr_rdata[2*W-1:W];

    always_comb begin
        case (state_reg)
            ST_RD_D: nb_bound = (r_reg == '0);
            ST_RD_L: nb_bound = last_row;
            ST_RD_R: nb_bound = (c_reg == '0);
            ST_NB_R: nb_bound = last_col;
            default: nb_bound = 1'b1;
        endcase
    end
    assign nb_wall = nb_bound || fl_rdata[0];

    // Shared multiplier operands.
    always_comb begin
        case (state_reg)
            ST_M_P:  begin
                mul_a = DW'(pv_reg);
                mul_b = CFG_BITS'($signed({1'b0, mu_reg}) - 18'sd65536);
            end
            ST_M_R:  begin
                mul_a = diff_reg;
                mul_b = $signed({2'b00, rho_reg});
            end
            default: begin
                mul_a = DW'(cv_reg);
                mul_b = gain_reg;
            end
        endcase
    end

    assign prod_rnd = prod_reg[PW-1] ? -((-prod_reg + PW'(32768)) >>> 16)
                                     : ((prod_reg + PW'(32768)) >>> 16);

    always_comb begin
        case (nw_reg)
            3'd1:    nwcb = (CBW+3)'(cb_reg);
            3'd2:    nwcb = (CBW+3)'(cb_reg) <<< 1;
            3'd3:    nwcb = ((CBW+3)'(cb_reg) <<< 1) + (CBW+3)'(cb_reg);
            3'd4:    nwcb = (CBW+3)'(cb_reg) <<< 2;
            default: nwcb = '0;
        endcase
    end

    assign divisor = {1'b1, mu_reg};
    assign mag = (num_reg[NB-1] ? NB'(-num_reg) : NB'(num_reg)) + NB'(divisor >> 1);

    assign v_raw = neg_reg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
    assign v_sum = v_raw + (exc_reg ? VW'(sample_reg) : VW'(0));
    assign v_clip = (v_sum > PMAX) || (v_sum < PMIN);
    assign v_sat  = (v_sum > PMAX) ? PMAX : ((v_sum < PMIN) ? PMIN : v_sum);

    assign lp_wide = 64'(lp_reg);

    // Memory write ports.
    always_comb begin
        fl_we    = 1'b0;
        fl_waddr = clr_reg;
        fl_wdata = '0;
        pr_we    = 1'b0;
        pr_waddr = clr_reg;
        pr_wdata = '0;
        if (state_reg == ST_CLEAR) begin
            fl_we = 1'b1;
            pr_we = 1'b1;
        end else if (state_reg == ST_IDLE) begin
            fl_we    = s_valid && (s_kind == KIND_CELL_WRITE) && in_grid;
            fl_waddr = AW'(int'(s_cell_row) * GRID_COLS + int'(s_cell_col));
            fl_wdata = {s_cell_excited, s_cell_is_wall};
        end else if (state_reg == ST_WB) begin
            pr_we    = 1'b1;
            pr_waddr = addr_c;
            pr_wdata = plane_reg ? {cv_reg, W'(v_sat)} : {W'(v_sat), cv_reg};
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && (s_kind == KIND_AUDIO_STEP)) begin
                    if (dcols_reg == '0 || drows_reg == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_RD_C;
                    end
                end
            end
            ST_RD_C:     state_next = ST_RD_U;
            ST_RD_U:     state_next = ST_RD_D;
            ST_RD_D:     state_next = ST_RD_L;
            ST_RD_L:     state_next = ST_RD_R;
            ST_RD_R:     state_next = ST_NB_R;
            ST_NB_R:     state_next = ST_M_CB;
            ST_M_CB:     state_next = ST_M_P;
            ST_M_P:      state_next = ST_M_S;
            ST_M_S:      state_next = ST_M_R;
            ST_M_R:      state_next = ST_M_N;
            ST_M_N:      state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_st.done) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                if (last_col && last_row) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_RD_C;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            plane_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == ST_DONE && out_free) begin
                plane_reg   <= !plane_reg;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        prod_reg <= PW'(mul_a * mul_b);
        case (state_reg)
            ST_IDLE: begin
                sample_reg <= s_sample_in;
                cols_reg   <= (int'(dcols_reg) > GRID_COLS) ? CCW'(GRID_COLS) : CCW'(dcols_reg);
                rows_reg   <= (int'(drows_reg) > GRID_ROWS) ? RCW'(GRID_ROWS) : RCW'(drows_reg);
                lis_ok_reg <= (lcol_reg != '0) && (lrow_reg != '0)
                              && (int'(lcol_reg) <= int'(dcols_reg))
                              && (int'(lrow_reg) <= int'(drows_reg))
                              && (int'(lcol_reg) <= GRID_COLS)
                              && (int'(lrow_reg) <= GRID_ROWS);
                lp_reg     <= '0;
                clip_reg   <= 1'b0;
                c_reg      <= '0;
                r_reg      <= '0;
            end
            ST_RD_U: begin
                cv_reg  <= rd_cur;
                pv_reg  <= rd_oth;
                exc_reg <= fl_rdata[1];
                sa_reg  <= '0;
                nw_reg  <= '0;
            end
            ST_RD_D, ST_RD_L, ST_RD_R, ST_NB_R: begin
                if (nb_wall) begin
                    nw_reg <= nw_reg + 1'b1;
                end else begin
                    sa_reg <= sa_reg + SW'(rd_cur);
                end
            end
            ST_M_P: begin
                cb_reg <= CBW'(prod_rnd);
            end
            ST_M_S: begin
                num_reg  <= (NB'(cv_reg) <<< 17) + NB'(prod_reg);
                diff_reg <= DW'(SW'(sa_reg)) + DW'(nwcb) - (DW'(cv_reg) <<< 2);
            end
            ST_M_N: begin
                num_reg <= num_reg + NB'(prod_reg);
            end
            ST_DIV_GO: begin
                neg_reg <= num_reg[NB-1];
            end
            ST_WB: begin
                if (v_clip) begin
                    clip_reg <= 1'b1;
                end
                if (at_listener) begin
                    lp_reg <= W'(v_sat);
                end
                if (last_col) begin
                    c_reg <= '0;
                    r_reg <= r_reg + 1'b1;
                end else begin
                    c_reg <= c_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_clip_reg <= clip_reg;
                    if (lp_wide > 64'sd8388607) begin
                        m_lp_reg <= 24'sh7FFFFF;
                    end else if (lp_wide < -64'sd8388608) begin
                        m_lp_reg <= 24'sh800000;
                    end else begin
                        m_lp_reg <= lp_wide[SAMPLE_BITS-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    dfm_mem #(.DEPTH(DEPTH), .WIDTH(2 * W)) u_press (
        .aclk  (aclk),
        .we    (pr_we),
        .waddr (pr_waddr),
        .wdata (pr_wdata),
        .raddr (raddr),
        .rdata (pr_rdata)
    );

    dfm_mem #(.DEPTH(DEPTH), .WIDTH(2)) u_flags (
        .aclk  (aclk),
        .we    (fl_we),
        .waddr (fl_waddr),
        .wdata (fl_wdata),
        .raddr (raddr),
        .rdata (fl_rdata)
    );

    dfm_div #(.NB(NB)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_DIV_GO),
        .dividend (mag),
        .divisor  (divisor),
        .quotient (quotient),
        .status   (div_st)
    );

    assign m_valid             = m_valid_reg;
    assign m_listener_pressure = m_lp_reg;
    assign m_clipped           = m_clip_reg;
endmodule
`default_nettype wire

@@ hdl/dfm_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfm_mem
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dfm_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 48
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hdl/dfm_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfm_div
// Restoring unsigned divider by a 17-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dfm_div #(
    parameter int NB = 49
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [NB-1:0]                dividend,
    input  wire logic [dfm_pkg::DIV_BITS-1:0] divisor,
    output logic      [NB-1:0]                quotient,
    output dfm_pkg::div_status_t              status
);
    import dfm_pkg::*;

    localparam int CNTW = $clog2(NB + 1);

    logic [NB-1:0]       work_reg;
    logic [DIV_BITS-1:0] rem_reg;
    logic [CNTW-1:0]     cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DIV_BITS:0]   trial;
    logic                qbit;

    assign trial = {rem_reg, work_reg[NB-1]};
    assign qbit  = (trial >= {1'b0, divisor});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NB);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= dividend;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg  <= qbit ? DIV_BITS'(trial - {1'b0, divisor}) : DIV_BITS'(trial);
            work_reg <= {work_reg[NB-2:0], qbit};
        end
    end

    assign quotient    = work_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;
endmodule
`default_nettype wire

@@ hdl/dfm_chk.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfm_chk
// Port-level checks of the drum membrane step engine.
// ----------------------------------------------------------------------------
module dfm_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_kind,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [23:0] m_listener_pressure,
    input wire logic        m_clipped
);
    import dfm_pkg::*;

    // The cell store is swept clear after reset before any word is taken.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready) else $error("ready during clearing pass");

    // An audio step keeps the block busy at least for the next cycle.
    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == KIND_AUDIO_STEP) |=> !s_ready)
        else $error("ready right after an audio step");

    // A result word appears only at the end of a step, never while idle.
    a_result_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready)) else $error("result without a step");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_listener_pressure)
        && $stable(m_clipped)) else $error("result word changed while stalled");
endmodule

bind drumhead_fdtd_membrane_step dfm_chk u_dfm_chk (.*);
`default_nettype wire

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Drum membrane time-step regression
// Cell writes and audio steps go through a valid/ready input port while the
// result port stalls on its own pattern. A behavioral copy of the grid
// predicts every listener word. Each listener word is checked field by field
// against the oldest prediction. Register settings change between idle
// phases. Most domains are small, and one full-size grid step is run.
// ----------------------------------------------------------------------------
module testbench;
    import dfm_pkg::*;

    localparam int NCOL = 64;
    localparam int NROW = 64;
    localparam longint PMAX = 64'sd8388607;
    localparam longint PMIN = -64'sd8388608;

    typedef struct {
        bit                  is_cfg;
        cfg_index_t          idx;
        logic [17:0]         val;
        logic                kind;
        logic [5:0]          col;
        logic [5:0]          row;
        logic                wall;
        logic                exc;
        logic signed [23:0]  smp;
        bit                  typed;
        logic signed [23:0]  ep;
        logic                ec;
    } stim_row_t;

    typedef struct {
        logic signed [23:0] pressure;
        logic               clip;
    } listen_word_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [CFG_BITS-1:0] cfg_data;
    logic s_valid, s_ready, s_kind, s_cell_is_wall, s_cell_excited;
    logic [5:0] s_cell_col, s_cell_row;
    logic signed [SAMPLE_BITS-1:0] s_sample_in;
    logic m_valid, m_ready, m_clipped;
    logic signed [SAMPLE_BITS-1:0] m_listener_pressure;

    int press_m [2][NROW][NCOL];
    bit wall_m [NROW][NCOL];
    bit exc_m [NROW][NCOL];
    bit cur_plane;
    int unsigned mu_q, rho_q, lcol_q, lrow_q, dcols_q, drows_q;
    longint gain_q;

    listen_word_t listen_q[$];
    stim_row_t dir_rows[$];
    int errors = 0;
    int burst_left = 0;
    bit hold_req = 1'b0;

    always #6 aclk = ~aclk;

    drumhead_fdtd_membrane_step i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_cell_col(s_cell_col), .s_cell_row(s_cell_row),
        .s_cell_is_wall(s_cell_is_wall), .s_cell_excited(s_cell_excited),
        .s_sample_in(s_sample_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_listener_pressure(m_listener_pressure), .m_clipped(m_clipped)
    );

    function automatic longint round_div(input longint n, input longint d);
        if (n >= 0)
            return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint side_pressure(input int r, input int c, input int rows,
                                             input int cols, input longint wall_p);
        if (r < 0 || c < 0 || r >= rows || c >= cols || wall_m[r][c])
            return wall_p;
        return press_m[cur_plane][r][c];
    endfunction

    function automatic void set_reg(input cfg_index_t idx, input logic [17:0] val);
        case (idx)
            REG_DAMPING_MU: mu_q = 32'(val[15:0]);
            REG_COUPLING_RHO: rho_q = 32'(val[15:0]);
            REG_BOUNDARY_GAIN: gain_q = longint'($signed(val));
            REG_LISTEN_COL: lcol_q = 32'(val[6:0]);
            REG_LISTEN_ROW: lrow_q = 32'(val[6:0]);
            REG_DOMAIN_COLS: dcols_q = 32'(val[6:0]);
            REG_DOMAIN_ROWS: drows_q = 32'(val[6:0]);
            default: ;
        endcase
    endfunction

    // Advances the predicted grid by one step and returns the listener word.
    function automatic listen_word_t advance_grid(input logic signed [23:0] smp);
        listen_word_t w;
        int rows, cols;
        bit oth;
        longint cc, pp, cb, s, num, v, lp;
        cols = dcols_q > NCOL ? NCOL : int'(dcols_q);
        rows = drows_q > NROW ? NROW : int'(drows_q);
        oth = ~cur_plane;
        w.clip = 1'b0;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                cc = press_m[cur_plane][r][c];
                pp = press_m[oth][r][c];
                cb = round_div(cc * gain_q, 65536);
                s = side_pressure(r - 1, c, rows, cols, cb) + side_pressure(r + 1, c, rows, cols, cb)
                  + side_pressure(r, c - 1, rows, cols, cb) + side_pressure(r, c + 1, rows, cols, cb);
                num = cc * 2 * 65536 + (longint'(mu_q) - 65536) * pp
                    + (s - 4 * cc) * longint'(rho_q);
                v = round_div(num, 65536 + longint'(mu_q));
                if (exc_m[r][c])
                    v += longint'(smp);
                if (v > PMAX) begin
                    v = PMAX;
                    w.clip = 1'b1;
                end
                if (v < PMIN) begin
                    v = PMIN;
                    w.clip = 1'b1;
                end
                press_m[oth][r][c] = int'(v);
            end
        end
        cur_plane = oth;
        lp = 0;
        if (lcol_q >= 1 && lrow_q >= 1 && lcol_q <= cols && lrow_q <= rows)
            lp = press_m[oth][lrow_q - 1][lcol_q - 1];
        w.pressure = lp[23:0];
        return w;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge aclk) begin
        listen_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (listen_q.size() == 0) begin
                report("unexpected listener word", m_listener_pressure, 0);
            end else begin
                want = listen_q.pop_front();
                if (m_listener_pressure !== want.pressure)
                    report("listener_pressure", m_listener_pressure, want.pressure);
                if (m_clipped !== want.clip)
                    report("clipped", m_clipped, want.clip);
            end
        end
    end

    // The receiver switches among four stall patterns at random and holds off
    // for a long stretch once when asked.
    initial begin
        int mode, tick, hold_left;
        mode = 0;
        tick = 0;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 3000;
            end
            tick++;
            if (tick % 64 == 0)
                mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= tick[0];
                endcase
            end
        end
    end

    task automatic push_item(input stim_row_t it);
        listen_word_t w;
        s_valid <= 1'b1;
        s_kind <= it.kind;
        s_cell_col <= it.col;
        s_cell_row <= it.row;
        s_cell_is_wall <= it.wall;
        s_cell_excited <= it.exc;
        s_sample_in <= it.smp;
        do @(posedge aclk); while (!s_ready);
        if (it.kind == KIND_CELL_WRITE) begin
            wall_m[it.row][it.col] = it.wall;
            exc_m[it.row][it.col] = it.exc;
        end else begin
            w = advance_grid(it.smp);
            if (it.typed) begin
                w.pressure = it.ep;
                w.clip = it.ec;
            end
            listen_q.push_back(w);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (listen_q.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [17:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        set_reg(idx, val);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic stim_row_t cfg_row(input cfg_index_t idx, input logic [17:0] val);
        stim_row_t r;
        r = '{default: '0, idx: REG_DAMPING_MU};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    function automatic stim_row_t wr_row(input int col, input int row, input bit wall,
                                         input bit exc);
        stim_row_t r;
        r = '{default: '0, idx: REG_DAMPING_MU};
        r.kind = KIND_CELL_WRITE;
        r.col = 6'(col);
        r.row = 6'(row);
        r.wall = wall;
        r.exc = exc;
        return r;
    endfunction

    function automatic stim_row_t step_row(input int smp, input bit typed = 0,
                                           input int ep = 0, input bit ec = 0);
        stim_row_t r;
        r = '{default: '0, idx: REG_DAMPING_MU};
        r.kind = KIND_AUDIO_STEP;
        r.smp = 24'(smp);
        r.typed = typed;
        r.ep = 24'(ep);
        r.ec = ec;
        return r;
    endfunction

    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return -24'sh800000;
            2: return 24'($urandom());
            default: return 24'($signed(24'($urandom_range(0, 65535))) - 32768);
        endcase
    endfunction

    function automatic logic [17:0] pick(input int sel, input logic [17:0] lo,
                                         input logic [17:0] hi, input logic [17:0] rnd);
        if (sel == 0)
            return lo;
        if (sel == 1)
            return hi;
        return rnd;
    endfunction

    initial begin
        stim_row_t it;
        int dc, dr, n_items;
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_DAMPING_MU;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_kind <= KIND_CELL_WRITE;
        s_cell_col <= '0;
        s_cell_row <= '0;
        s_cell_is_wall <= 1'b0;
        s_cell_excited <= 1'b0;
        s_sample_in <= '0;
        press_m = '{default: '{default: '{default: 0}}};
        wall_m = '{default: '{default: 0}};
        exc_m = '{default: '{default: 0}};
        cur_plane = 1'b0;
        mu_q = 66;
        rho_q = 32768;
        gain_q = 0;
        lcol_q = 1;
        lrow_q = 1;
        dcols_q = 64;
        drows_q = 64;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        dir_rows.push_back(cfg_row(REG_DOMAIN_COLS, 18'd4));
        dir_rows.push_back(cfg_row(REG_DOMAIN_ROWS, 18'd4));
        dir_rows.push_back(step_row(0, 1, 0, 0));
        dir_rows.push_back(wr_row(0, 0, 0, 1));
        dir_rows.push_back(step_row(8388607, 1, 8388607, 0));
        dir_rows.push_back(step_row(-8388608));
        dir_rows.push_back(wr_row(63, 63, 1, 1));
        dir_rows.push_back(wr_row(1, 1, 1, 0));
        dir_rows.push_back(wr_row(2, 1, 0, 1));
        dir_rows.push_back(cfg_row(REG_BOUNDARY_GAIN, 18'h10000));
        dir_rows.push_back(cfg_row(REG_DAMPING_MU, 18'hFFFF));
        dir_rows.push_back(cfg_row(REG_COUPLING_RHO, 18'hFFFF));
        dir_rows.push_back(step_row(8388607));
        dir_rows.push_back(step_row(12345));
        dir_rows.push_back(cfg_row(REG_BOUNDARY_GAIN, 18'h30000));
        dir_rows.push_back(cfg_row(REG_DAMPING_MU, 18'd0));
        dir_rows.push_back(cfg_row(REG_COUPLING_RHO, 18'd0));
        dir_rows.push_back(step_row(-8388608));
        dir_rows.push_back(cfg_row(REG_LISTEN_COL, 18'd0));
        dir_rows.push_back(step_row(777));
        dir_rows.push_back(cfg_row(REG_LISTEN_COL, 18'd5));
        dir_rows.push_back(step_row(-777));
        dir_rows.push_back(cfg_row(REG_DOMAIN_COLS, 18'd0));
        dir_rows.push_back(step_row(100, 1, 0, 0));
        dir_rows.push_back(cfg_row(REG_DOMAIN_COLS, 18'd127));
        dir_rows.push_back(cfg_row(REG_DOMAIN_ROWS, 18'd1));
        dir_rows.push_back(cfg_row(REG_LISTEN_COL, 18'd64));
        dir_rows.push_back(cfg_row(REG_LISTEN_ROW, 18'd1));
        dir_rows.push_back(wr_row(63, 0, 0, 1));
        dir_rows.push_back(step_row(4000));
        dir_rows.push_back(step_row(-4000));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                drain();
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            end else begin
                push_item(dir_rows[i]);
            end
        end

        // Random phases: small domains, with the extremes of each register in turn.
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            dc = (ph == 2) ? 2 : $urandom_range(1, 8);
            dr = (ph == 2) ? 2 : $urandom_range(1, 8);
            write_reg(REG_DAMPING_MU,
                      pick(ph % 3, 18'd0, 18'hFFFF, 18'($urandom_range(0, 65535))));
            write_reg(REG_COUPLING_RHO,
                      pick((ph + 1) % 3, 18'd0, 18'hFFFF, 18'($urandom_range(0, 65535))));
            write_reg(REG_BOUNDARY_GAIN,
                      pick((ph + 2) % 3, 18'h30000, 18'h10000, 18'($urandom_range(0, 131072) - 65536)));
            write_reg(REG_LISTEN_COL, 18'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                                       : $urandom_range(1, dc)));
            write_reg(REG_LISTEN_ROW, 18'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                                       : $urandom_range(1, dr)));
            write_reg(REG_DOMAIN_COLS, 18'(dc));
            write_reg(REG_DOMAIN_ROWS, 18'(dr));
            if (ph == 2)
                hold_req = 1'b1;
            n_items = (ph == 2) ? 30 : 13;
            for (int k = 0; k < n_items; k++) begin
                it = step_row(0);
                if ($urandom_range(0, 9) < ((ph == 2) ? 2 : 6)) begin
                    it.kind = KIND_CELL_WRITE;
                    if ($urandom_range(0, 6) == 0) begin
                        it.col = 6'($urandom());
                        it.row = 6'($urandom());
                    end else begin
                        it.col = 6'($urandom_range(0, dc - 1));
                        it.row = 6'($urandom_range(0, dr - 1));
                    end
                    it.wall = ($urandom_range(0, 3) == 0);
                    it.exc = 1'($urandom_range(0, 1));
                end
                it.smp = rand_sample();
                push_item(it);
            end
        end

        // One step over the whole grid.
        drain();
        write_reg(REG_DOMAIN_COLS, 18'd64);
        write_reg(REG_DOMAIN_ROWS, 18'd64);
        write_reg(REG_LISTEN_COL, 18'd64);
        write_reg(REG_LISTEN_ROW, 18'd64);
        write_reg(REG_DAMPING_MU, 18'd66);
        write_reg(REG_COUPLING_RHO, 18'd32768);
        write_reg(REG_BOUNDARY_GAIN, 18'h08000);
        push_item(wr_row(63, 63, 0, 1));
        push_item(step_row(-3000000));
        drain();
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #(12 * 4000000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
hdl/dfm_pkg.sv
hdl/dfm_mem.sv
hdl/dfm_div.sv
hdl/drumhead_fdtd_membrane_step.sv
hdl/dfm_chk.sv
test/testbench.sv
